[rtl/frustum_cull_tester_top_macros.svh]
// ----------------------------------------------------------------------------
// frustum_cull_tester_top_macros.svh
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TESTER_TOP_MACROS_SVH
`define FRUSTUM_CULL_TESTER_TOP_MACROS_SVH

// Generic clocked assertion with asynchronous active-low reset disable.
`define FC_ASSERT(label, clock, resetn, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);

// Same, on the usual clk / rst_n pair.
`define FC_ASSERT_CLK(label, prop, msg) \
    `FC_ASSERT(label, clk, rst_n, prop, msg)

`endif

[rtl/fcull_pkg.sv]
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared constants, types and helpers for the frustum cull tester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcull_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int FRAC_BITS   = 16;

    localparam int DATA_W  = 32;
    localparam int COEF_W  = DATA_W + 1;
    localparam int PROD_W  = COEF_W + DATA_W;
    localparam int ACC_W   = 68;
    localparam int RAD_W   = 31;

    localparam int STEP_COUNT = PLANE_COUNT * 4;
    localparam int STEP_W     = $clog2(STEP_COUNT);
    localparam int PLANE_W    = STEP_W - 2;

    typedef logic signed [DATA_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam coord_t FIXED_ONE = coord_t'(64'sd1 <<< FRAC_BITS);

    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_POINT  = 3'd1;
    localparam logic [2:0] MODE_SPHERE = 3'd2;
    localparam logic [2:0] MODE_BOX_IN = 3'd3;
    localparam logic [2:0] MODE_BOX_HIT = 3'd4;

    localparam logic [1:0] TERM_DIST = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Tag that travels with one term down the multiply-accumulate pipe.
    typedef struct packed {
        logic       valid;
        logic [1:0] term;
        logic       last;
    } tag_t;

    // Left, bottom and near planes add the row; the others subtract it.
    function automatic logic plane_is_plus(input logic [PLANE_W-1:0] plane);
        return (plane == PLANE_W'(0)) || (plane == PLANE_W'(3)) || (plane == PLANE_W'(4));
    endfunction

endpackage

`default_nettype wire

[rtl/fcull_mac.sv]
// ----------------------------------------------------------------------------
// fcull_mac
// Shared multiplier and plane accumulator; folds plane signs into a verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcull_mac (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  clear,
    input  wire fcull_pkg::coef_t      coef,
    input  wire fcull_pkg::tag_t       tag,
    input  wire fcull_pkg::coord_t     lo_x,
    input  wire fcull_pkg::coord_t     lo_y,
    input  wire fcull_pkg::coord_t     lo_z,
    input  wire fcull_pkg::coord_t     hi_x,
    input  wire fcull_pkg::coord_t     hi_y,
    input  wire fcull_pkg::coord_t     hi_z,
    input  wire logic                  want_min,
    input  wire fcull_pkg::acc_t       extra,
    output logic                       done,
    output logic                       verdict
);
    import fcull_pkg::*;

    coord_t operand;
    logic   take_lo;
    prod_t  prod_reg;
    tag_t   s3_tag_reg;
    acc_t   acc_reg;
    acc_t   acc_base;
    acc_t   acc_sum;
    logic   plane_neg;
    logic   ok_reg;
    logic   done_reg;
    logic   verdict_reg;

    // corner pick: nonnegative coefficient takes the low edge for the
    // containment test, the high edge for the overlap test
    always_comb
    begin
        take_lo = (~coef[COEF_W-1]) == want_min;
        case (tag.term)
            2'd0:    operand = take_lo ? lo_x : hi_x;
            2'd1:    operand = take_lo ? lo_y : hi_y;
            2'd2:    operand = take_lo ? lo_z : hi_z;
            default: operand = FIXED_ONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * operand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_tag_reg <= '0;
        end
        else
        begin
            s3_tag_reg <= tag;
        end
    end

    always_comb
    begin
        acc_base  = (s3_tag_reg.term == 2'd0) ? extra : acc_reg;
        acc_sum   = acc_base + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        plane_neg = (s3_tag_reg.term == TERM_DIST) && acc_sum[ACC_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (s3_tag_reg.valid)
        begin
            acc_reg <= acc_sum;
        end
        if (s3_tag_reg.valid && s3_tag_reg.last)
        begin
            verdict_reg <= ok_reg && !plane_neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg   <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_tag_reg.valid && s3_tag_reg.last;
            if (clear)
            begin
                ok_reg <= 1'b1;
            end
            else if (s3_tag_reg.valid && plane_neg)
            begin
                ok_reg <= 1'b0;
            end
        end
    end

    assign done    = done_reg;
    assign verdict = verdict_reg;

endmodule

`default_nettype wire

[rtl/frustum_cull_tester_top.sv]
// ----------------------------------------------------------------------------
// frustum_cull_tester_top
// View-frustum plane extraction and point/sphere/box culling tests.
// ----------------------------------------------------------------------------
// Results: done and verdict are registered together at the accumulate stage.
// A new test item is accepted only while busy is low; busy falls the cycle after done.
//   Each test runs 4 terms x PLANE_COUNT planes through the shared multiplier,
//   one term per cycle, via the read/coef/multiply/accumulate pipe.
// Load items finish in the accept cycle; busy never rises for them.
// Reset (rst_n low, async): sequencer idle, no result pending; the matrix
//   memory is not cleared and must be fully loaded before any test.
// Results cannot be stalled: done is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_tester_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [2:0]                     mode,
    input  wire logic [1:0]                     col_index,
    input  wire logic [1:0]                     row_index,
    input  wire fcull_pkg::coord_t              matrix_value,
    input  wire fcull_pkg::coord_t              px,
    input  wire fcull_pkg::coord_t              py,
    input  wire fcull_pkg::coord_t              pz,
    input  wire logic [fcull_pkg::RAD_W-1:0]    radius,
    input  wire fcull_pkg::coord_t              qx,
    input  wire fcull_pkg::coord_t              qy,
    input  wire fcull_pkg::coord_t              qz,
    output logic                                done,
    output logic                                verdict
);
    import fcull_pkg::*;

    // ---------------------------------------------------------------- control
    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic                issue;
    logic                accept;
    logic                is_test;
    logic                test_accept;
    logic                load_accept;
    logic                mac_done;

    // ------------------------------------------------------- item operands
    coord_t              lo_x_reg, lo_y_reg, lo_z_reg;
    coord_t              hi_x_reg, hi_y_reg, hi_z_reg;
    logic                want_min_reg;
    logic                sphere_reg;
    logic [RAD_W-1:0]    radius_reg;
    acc_t                extra;
    logic                is_box;

    // ------------------------------------------------ matrix memory / coef
    coord_t              matrix_mem [16];
    logic [3:0]          w_addr;
    logic [3:0]          e_addr;
    logic [1:0]          term;
    logic [PLANE_W-1:0]  plane;
    coord_t              rd_w_reg;
    coord_t              rd_e_reg;
    tag_t                s1_tag_reg;
    logic [PLANE_W-1:0]  s1_plane_reg;
    coef_t               coef_reg;
    tag_t                s2_tag_reg;
    coef_t               w_ext;
    coef_t               e_ext;

    assign accept      = start && !busy;
    assign is_test     = mode inside {[MODE_POINT:MODE_BOX_HIT]};
    assign test_accept = accept && is_test;
    assign load_accept = accept && (mode == MODE_LOAD);
    assign is_box      = (mode == MODE_BOX_IN) || (mode == MODE_BOX_HIT);

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (test_accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_reg == STEP_W'(STEP_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                busy  = 1'b0;
                issue = 1'b0;
            end
            ST_RUN:
            begin
                busy  = 1'b1;
                issue = 1'b1;
            end
            default:
            begin
                busy  = 1'b1;
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (test_accept)
            begin
                step_reg <= '0;
            end
            else if (issue)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // Capture operands; point and sphere use p for both edges so the
    // corner pick is a no-op.
    always_ff @(posedge clk)
    begin
        if (test_accept)
        begin
            lo_x_reg     <= (is_box && (qx < px)) ? qx : px;
            lo_y_reg     <= (is_box && (qy < py)) ? qy : py;
            lo_z_reg     <= (is_box && (qz < pz)) ? qz : pz;
            hi_x_reg     <= (is_box && (px < qx)) ? qx : px;
            hi_y_reg     <= (is_box && (py < qy)) ? qy : py;
            hi_z_reg     <= (is_box && (pz < qz)) ? qz : pz;
            want_min_reg <= (mode == MODE_BOX_IN);
            sphere_reg   <= (mode == MODE_SPHERE);
            radius_reg   <= radius;
        end
    end

    // radius is added at Q.(2*FRAC) scale, like the products
    assign extra = sphere_reg ? (ACC_W'(radius_reg) << FRAC_BITS) : '0;

    // ------------------------------------------------ matrix memory, stage 1
    // Column-major: element (col, row) lives at col*4 + row.
    assign term   = step_reg[1:0];
    assign plane  = step_reg[STEP_W-1:2];
    assign w_addr = {term, 2'd3};
    assign e_addr = {term, 2'(plane >> 1)};

    always_ff @(posedge clk)
    begin
        if (load_accept)
        begin
            matrix_mem[{col_index, row_index}] <= matrix_value;
        end
        rd_w_reg <= matrix_mem[w_addr];
        rd_e_reg <= matrix_mem[e_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg.valid <= issue;
            s1_tag_reg.term  <= term;
            s1_tag_reg.last  <= (step_reg == STEP_W'(STEP_COUNT - 1));
            s2_tag_reg       <= s1_tag_reg;
        end
    end

    // ------------------------------------------------- stage 2: coefficient
    assign w_ext = {rd_w_reg[DATA_W-1], rd_w_reg};
    assign e_ext = {rd_e_reg[DATA_W-1], rd_e_reg};

    always_ff @(posedge clk)
    begin
        s1_plane_reg <= plane;
        coef_reg     <= plane_is_plus(s1_plane_reg) ? (w_ext + e_ext) : (w_ext - e_ext);
    end

    // ------------------------------------- stages 3-4: multiply, accumulate
    fcull_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (test_accept),
        .coef     (coef_reg),
        .tag      (s2_tag_reg),
        .lo_x     (lo_x_reg),
        .lo_y     (lo_y_reg),
        .lo_z     (lo_z_reg),
        .hi_x     (hi_x_reg),
        .hi_y     (hi_y_reg),
        .hi_z     (hi_z_reg),
        .want_min (want_min_reg),
        .extra    (extra),
        .done     (mac_done),
        .verdict  (verdict)
    );

    assign done = mac_done;

endmodule

`default_nettype wire

[rtl/fcull_checker.sv]
// ----------------------------------------------------------------------------
// fcull_checker
// Port-level temporal checks on the frustum cull tester, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frustum_cull_tester_top_macros.svh"

module fcull_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [2:0] mode,
    input wire logic       done
);
    import fcull_pkg::*;

    `FC_ASSERT_CLK(a_done_pulse, done |=> !done, "done held longer than one cycle")
    `FC_ASSERT_CLK(a_load_quick, (start && !busy && mode == MODE_LOAD) |=> !busy, "load raised busy")
    `FC_ASSERT_CLK(a_test_busy, (start && !busy && (mode == MODE_POINT || mode == MODE_SPHERE || mode == MODE_BOX_IN || mode == MODE_BOX_HIT)) |=> busy, "test item did not raise busy")
    `FC_ASSERT_CLK(a_done_in_busy, done |-> busy, "result outside a busy window")
    `FC_ASSERT_CLK(a_busy_end, $fell(busy) |-> $past(done), "busy dropped without a result")

endmodule

bind frustum_cull_tester_top fcull_checker u_fcull_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .done  (done)
);

`default_nettype wire
